[hw/rtl/bounded_lifo_stack_with_reverse_top_assert.svh]
// Assertion macros shared by the stack RTL.
// Expects a clock named clk and an active-low reset named arst_n in scope.
`ifndef BOUNDED_LIFO_STACK_WITH_REVERSE_TOP_ASSERT_SVH
`define BOUNDED_LIFO_STACK_WITH_REVERSE_TOP_ASSERT_SVH

// property must hold at every clock edge outside reset
`define BLSR_ASSERT(name, prop, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// condition must never be seen outside reset
`define BLSR_ASSERT_NEVER(name, cond, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);

`endif

[hw/rtl/blsr_pkg.sv]
// Shared types and constants of the bounded LIFO stack.
// No dependencies.
package blsr_pkg;

	localparam int unsigned OUT_WIDTH   = 32;
	localparam int unsigned COUNT_WIDTH = 7;

	typedef enum logic [1:0] {
		MODE_PUSH    = 2'd0,
		MODE_POP     = 2'd1,
		MODE_PEEK    = 2'd2,
		MODE_REVERSE = 2'd3
	} mode_t;

endpackage

[hw/rtl/blsr_ram.sv]
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module blsr_ram #(
	parameter int unsigned WIDTH = 32,
	parameter int unsigned DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

[hw/rtl/bounded_lifo_stack_with_reverse_top.sv]
// Bounded LIFO stack of signed words with in-place reversal.
// Depends on blsr_pkg, blsr_ram and bounded_lifo_stack_with_reverse_top_assert.svh.
//
// Usage:
//   Request channel (req_valid/req_ready) carries mode and push_value. Modes: push,
//   pop, peek at the top, reverse the stored words in place.
//   Result channel (res_valid/res_ready) returns exactly one result per request:
//   read_value, empty_error, full_drop and entry_count (count after the request).
//   A push onto a full stack is dropped with full_drop set; pop or peek on an empty
//   stack answers -1 with empty_error set.
//   One request is worked on at a time. A push goes straight to the finish state,
//   a pop or peek passes a read state for the registered RAM read, and a reverse
//   swaps pairs from both ends inward: each swap reads the low and high entries through
//   the single RAM read port and writes them back through the single write port.
//   A finished result sits in the output register; the next request is taken
//   while it waits. If the receiver stalls long enough, the following result
//   holds in a finish state and req_ready stays low until the output frees up.
//   Reset (arst_n low) empties the stack and drops any pending result; the word
//   store itself is not cleared, only entries below the count are ever read.
module bounded_lifo_stack_with_reverse_top #(
	parameter int unsigned STACK_DEPTH = 64,
	parameter int unsigned WORD_WIDTH  = 32
) (
	input  logic                                      clk,
	input  logic                                      arst_n,
	input  logic                                      req_valid,
	output logic                                      req_ready,
	input  logic [1:0]                                mode,
	input  logic signed [blsr_pkg::OUT_WIDTH-1:0]     push_value,
	output logic                                      res_valid,
	input  logic                                      res_ready,
	output logic signed [blsr_pkg::OUT_WIDTH-1:0]     read_value,
	output logic                                      empty_error,
	output logic                                      full_drop,
	output logic [blsr_pkg::COUNT_WIDTH-1:0]          entry_count
);

	`include "bounded_lifo_stack_with_reverse_top_assert.svh"

	localparam int unsigned AW = $clog2(STACK_DEPTH);
	localparam int unsigned CW = $clog2(STACK_DEPTH + 1);
	localparam int unsigned OW = blsr_pkg::OUT_WIDTH;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_RD,
		ST_REV_RD_LO,
		ST_REV_RD_HI,
		ST_REV_WR_LO,
		ST_REV_WR_HI,
		ST_FIN
	} state_t;

	state_t                state_q;
	logic [CW-1:0]         count_q;
	logic [AW-1:0]         lo_q;
	logic [AW-1:0]         hi_q;
	logic [WORD_WIDTH-1:0] lo_word_q;
	logic                  is_pop_q;

	// staged result, waiting for the output register
	logic [OW-1:0]         fin_value_q;
	logic                  fin_empty_q;
	logic                  fin_drop_q;

	// output register
	logic                  res_valid_q;
	logic [OW-1:0]         res_value_q;
	logic                  res_empty_q;
	logic                  res_drop_q;
	logic [CW-1:0]         res_count_q;

	logic                  req_acc;
	logic                  stack_full;
	logic                  stack_empty;
	logic [AW-1:0]         top_addr;
	logic                  out_free;
	logic                  rev_more;

	logic                  ram_we;
	logic [AW-1:0]         ram_waddr;
	logic [WORD_WIDTH-1:0] ram_wdata;
	logic                  ram_re;
	logic [AW-1:0]         ram_raddr;
	logic [WORD_WIDTH-1:0] ram_rdata;

	logic [WORD_WIDTH-1:0] push_word;
	logic [OW-1:0]         rd_ext;

	logic                  rev_wr;
	logic                  rev_busy;
	logic                  push_ok;
	logic                  read_ok;

	// fit pushed and read words between the widths; narrow read words are sign-extended
	if (WORD_WIDTH <= OW) begin : g_narrow
		assign push_word = push_value[WORD_WIDTH-1:0];
		if (WORD_WIDTH < OW) begin : g_ext
			assign rd_ext = {{(OW - WORD_WIDTH){ram_rdata[WORD_WIDTH-1]}}, ram_rdata};
		end else begin : g_same
			assign rd_ext = ram_rdata;
		end
	end else begin : g_wide
		assign push_word = {{(WORD_WIDTH - OW){1'b0}}, push_value};
		assign rd_ext    = ram_rdata[OW-1:0];
	end

	assign req_ready   = (state_q == ST_IDLE);
	assign req_acc     = req_valid && req_ready;
	assign stack_full  = (count_q == CW'(STACK_DEPTH));
	assign stack_empty = (count_q == '0);
	assign top_addr    = AW'(count_q - CW'(1));
	assign out_free    = !res_valid_q || res_ready;
	// another swap is left when the pointers stay apart after stepping
	assign rev_more    = ((AW + 1)'(lo_q) + (AW + 1)'(2)) < (AW + 1)'(hi_q);

	// RAM port steering
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = lo_q;
		ram_wdata = lo_word_q;
		ram_re    = 1'b0;
		ram_raddr = lo_q;
		unique case (state_q)
			ST_IDLE: begin
				if (req_acc) begin
					case (blsr_pkg::mode_t'(mode))
						blsr_pkg::MODE_PUSH: begin
							ram_we    = !stack_full;
							ram_waddr = AW'(count_q);
							ram_wdata = push_word;
						end
						blsr_pkg::MODE_POP, blsr_pkg::MODE_PEEK: begin
							ram_re    = !stack_empty;
							ram_raddr = top_addr;
						end
						default: begin
						end
					endcase
				end
			end
			ST_REV_RD_LO: begin
				ram_re    = 1'b1;
				ram_raddr = lo_q;
			end
			ST_REV_RD_HI: begin
				ram_re    = 1'b1;
				ram_raddr = hi_q;
			end
			ST_REV_WR_LO: begin
				ram_we    = 1'b1;
				ram_waddr = lo_q;
				ram_wdata = ram_rdata;
			end
			ST_REV_WR_HI: begin
				ram_we    = 1'b1;
				ram_waddr = hi_q;
				ram_wdata = lo_word_q;
			end
			default: begin
			end
		endcase
	end

	// control state and registered outputs
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			res_valid_q <= 1'b0;
		end else begin
			// drop the output once taken, unless a new result replaces it
			if (res_valid_q && res_ready && state_q != ST_FIN) begin
				res_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (req_acc) begin
						case (blsr_pkg::mode_t'(mode))
							blsr_pkg::MODE_PUSH: begin
								fin_value_q <= '0;
								fin_empty_q <= 1'b0;
								fin_drop_q  <= stack_full;
								if (!stack_full) begin
									count_q <= count_q + CW'(1);
								end
								state_q <= ST_FIN;
							end
							blsr_pkg::MODE_POP, blsr_pkg::MODE_PEEK: begin
								// empty stack answers all ones
								fin_value_q <= {OW{stack_empty}};
								fin_empty_q <= stack_empty;
								fin_drop_q  <= 1'b0;
								is_pop_q    <= (blsr_pkg::mode_t'(mode) == blsr_pkg::MODE_POP);
								state_q     <= stack_empty ? ST_FIN : ST_RD;
							end
							default: begin
								fin_value_q <= '0;
								fin_empty_q <= 1'b0;
								fin_drop_q  <= 1'b0;
								if (count_q >= CW'(2)) begin
									lo_q    <= '0;
									hi_q    <= top_addr;
									state_q <= ST_REV_RD_LO;
								end else begin
									state_q <= ST_FIN;
								end
							end
						endcase
					end
				end
				ST_RD: begin
					fin_value_q <= rd_ext;
					if (is_pop_q) begin
						count_q <= count_q - CW'(1);
					end
					state_q <= ST_FIN;
				end
				ST_REV_RD_LO: begin
					state_q <= ST_REV_RD_HI;
				end
				ST_REV_RD_HI: begin
					lo_word_q <= ram_rdata;
					state_q   <= ST_REV_WR_LO;
				end
				ST_REV_WR_LO: begin
					state_q <= ST_REV_WR_HI;
				end
				ST_REV_WR_HI: begin
					lo_q    <= lo_q + AW'(1);
					hi_q    <= hi_q - AW'(1);
					state_q <= rev_more ? ST_REV_RD_LO : ST_FIN;
				end
				ST_FIN: begin
					// hold the result until the output register frees up
					if (out_free) begin
						res_valid_q <= 1'b1;
						res_value_q <= fin_value_q;
						res_empty_q <= fin_empty_q;
						res_drop_q  <= fin_drop_q;
						res_count_q <= count_q;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	blsr_ram #(
		.WIDTH (WORD_WIDTH),
		.DEPTH (STACK_DEPTH)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	assign res_valid   = res_valid_q;
	assign read_value  = res_value_q;
	assign empty_error = res_empty_q;
	assign full_drop   = res_drop_q;
	if (CW >= blsr_pkg::COUNT_WIDTH) begin : g_cnt_trunc
		assign entry_count = res_count_q[blsr_pkg::COUNT_WIDTH-1:0];
	end else begin : g_cnt_ext
		assign entry_count = {{(blsr_pkg::COUNT_WIDTH - CW){1'b0}}, res_count_q};
	end

	assign rev_wr   = (state_q == ST_REV_WR_LO) || (state_q == ST_REV_WR_HI);
	assign rev_busy = rev_wr || (state_q == ST_REV_RD_LO) || (state_q == ST_REV_RD_HI);
	assign push_ok  = req_acc && (mode == blsr_pkg::MODE_PUSH) && !stack_full;
	assign read_ok  = req_acc && !stack_empty
		&& (mode == blsr_pkg::MODE_POP || mode == blsr_pkg::MODE_PEEK);

	`BLSR_ASSERT_NEVER(a_count_bound, count_q > CW'(STACK_DEPTH), "count above depth")
	`BLSR_ASSERT(a_rev_order, rev_busy |-> (lo_q < hi_q), "reverse pointers crossed")
	`BLSR_ASSERT(a_store_wr, (ram_we && state_q != ST_IDLE) |-> rev_wr, "stray store write")
	`BLSR_ASSERT(a_push_cnt, push_ok |=> (count_q == $past(count_q) + CW'(1)), "push count")
	`BLSR_ASSERT(a_read_issue, read_ok |=> (state_q == ST_RD), "read of top not issued")

endmodule

[dv/tb_bounded_lifo_stack_with_reverse_top.sv]
// Self-checking testbench for bounded_lifo_stack_with_reverse_top: directed edge cases,
// then bursty random push/pop/peek/reverse traffic checked against a shadow stack.
// Depends on blsr_pkg and the stack RTL.
`timescale 1ns / 100ps

module tb_bounded_lifo_stack_with_reverse_top;

	localparam int unsigned DEPTH      = 64;
	localparam int unsigned WIDTH      = 32;
	// longest single request is a reverse of a full stack
	localparam int          DRAIN_WAIT = 4 * (DEPTH / 2) + 20;

	typedef struct packed {
		logic signed [blsr_pkg::OUT_WIDTH-1:0] value;
		logic                                  empty;
		logic                                  drop;
		logic [blsr_pkg::COUNT_WIDTH-1:0]      count;
	} stack_result_t;

	typedef enum int {
		BURST_FILL,
		BURST_DRAIN,
		BURST_MIX
	} burst_kind_t;

	logic                                  clk         = 1'b0;
	logic                                  arst_n      = 1'b0;
	logic                                  req_valid   = 1'b0;
	logic                                  req_ready;
	blsr_pkg::mode_t                       mode        = blsr_pkg::MODE_PUSH;
	logic signed [blsr_pkg::OUT_WIDTH-1:0] push_value  = '0;
	logic                                  res_valid;
	logic                                  res_ready   = 1'b0;
	logic signed [blsr_pkg::OUT_WIDTH-1:0] read_value;
	logic                                  empty_error;
	logic                                  full_drop;
	logic [blsr_pkg::COUNT_WIDTH-1:0]      entry_count;

	// percentage of cycles in which each side holds back
	int unsigned                   send_idle_pct = 32;
	int unsigned                   recv_idle_pct = 87;
	int unsigned                   mismatch_count = 0;

	// shadow copy of the stack contents, advanced on every accepted request
	logic signed [WIDTH-1:0]       shadow_words [DEPTH];
	int unsigned                   shadow_level = 0;
	stack_result_t                 expected_results [$];

	bounded_lifo_stack_with_reverse_top #(
		.STACK_DEPTH (DEPTH),
		.WORD_WIDTH  (WIDTH)
	) dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.req_valid   (req_valid),
		.req_ready   (req_ready),
		.mode        (mode),
		.push_value  (push_value),
		.res_valid   (res_valid),
		.res_ready   (res_ready),
		.read_value  (read_value),
		.empty_error (empty_error),
		.full_drop   (full_drop),
		.entry_count (entry_count)
	);

	always #5 clk = ~clk;

	// Apply one request to the shadow stack and return the result it must produce.
	function automatic stack_result_t apply_request(blsr_pkg::mode_t op,
			logic signed [WIDTH-1:0] word);
		stack_result_t           r;
		int unsigned             lo;
		int unsigned             hi;
		logic signed [WIDTH-1:0] swap;
		r = '0;
		case (op)
			blsr_pkg::MODE_PUSH: begin
				if (shadow_level >= DEPTH) begin
					r.drop = 1'b1;
				end else begin
					shadow_words[shadow_level] = word;
					shadow_level++;
				end
			end
			blsr_pkg::MODE_POP, blsr_pkg::MODE_PEEK: begin
				if (shadow_level == 0) begin
					// empty stack answers all ones with the flag raised
					r.value = -1;
					r.empty = 1'b1;
				end else begin
					r.value = shadow_words[shadow_level - 1];
					if (op == blsr_pkg::MODE_POP)
						shadow_level--;
				end
			end
			blsr_pkg::MODE_REVERSE: begin
				// swap from both ends inward; fewer than two entries leaves it alone
				if (shadow_level >= 2) begin
					lo = 0;
					hi = shadow_level - 1;
					while (lo < hi) begin
						swap             = shadow_words[lo];
						shadow_words[lo] = shadow_words[hi];
						shadow_words[hi] = swap;
						lo++;
						hi--;
					end
				end
			end
		endcase
		r.count = shadow_level[blsr_pkg::COUNT_WIDTH-1:0];
		return r;
	endfunction

	task automatic report_mismatch(string what);
		$display("[%0t] mismatch: %s", $time, what);
		mismatch_count++;
	endtask

	// Send one request: idle for a random gap, then hold valid and payload until
	// accepted. Valid stays high when the next request follows with no gap.
	task automatic send_request(blsr_pkg::mode_t op, logic signed [WIDTH-1:0] word);
		int unsigned gap;
		gap = 0;
		while (gap < 40 && $urandom_range(99) < send_idle_pct)
			gap++;
		@(negedge clk);
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		req_valid  <= 1'b1;
		mode       <= op;
		push_value <= word;
		do
			@(posedge clk);
		while (!req_ready);
		expected_results.push_back(apply_request(op, word));
	endtask

	// Receiver: drop ready at random on the falling edge.
	always @(negedge clk) begin
		res_ready <= ($urandom_range(99) >= recv_idle_pct);
	end

	// Result checker: compare every accepted result with the oldest expectation.
	always @(posedge clk) begin
		stack_result_t want;
		if (arst_n && res_valid && res_ready) begin
			if (expected_results.size() == 0) begin
				report_mismatch("result with no request pending");
			end else begin
				want = expected_results.pop_front();
				if (read_value !== want.value)
					report_mismatch($sformatf("read_value got %0d want %0d",
						read_value, want.value));
				if (empty_error !== want.empty)
					report_mismatch($sformatf("empty_error got %b want %b",
						empty_error, want.empty));
				if (full_drop !== want.drop)
					report_mismatch($sformatf("full_drop got %b want %b",
						full_drop, want.drop));
				if (entry_count !== want.count)
					report_mismatch($sformatf("entry_count got %0d want %0d",
						entry_count, want.count));
			end
		end
	end

	// Pop, peek and reverse on a freshly reset, empty stack.
	task automatic test_empty_reads();
		send_request(blsr_pkg::MODE_POP, '0);
		send_request(blsr_pkg::MODE_PEEK, '1);
		send_request(blsr_pkg::MODE_REVERSE, '0);
	endtask

	// Single entry: the most negative word, reversed in place and peeked.
	task automatic test_single_entry();
		send_request(blsr_pkg::MODE_PUSH, 32'sh8000_0000);
		send_request(blsr_pkg::MODE_REVERSE, '0);
		send_request(blsr_pkg::MODE_PEEK, '0);
	endtask

	// Extreme and alternating words, reversed at even and odd counts, then drained
	// past empty.
	task automatic test_reverse_orders();
		send_request(blsr_pkg::MODE_PUSH, 32'sh7FFF_FFFF);
		send_request(blsr_pkg::MODE_PUSH, -1);
		send_request(blsr_pkg::MODE_PUSH, '0);
		send_request(blsr_pkg::MODE_PUSH, 32'sh5555_5555);
		send_request(blsr_pkg::MODE_PUSH, 32'shAAAA_AAAA);
		send_request(blsr_pkg::MODE_REVERSE, '0);
		send_request(blsr_pkg::MODE_PEEK, '0);
		send_request(blsr_pkg::MODE_POP, '0);
		send_request(blsr_pkg::MODE_REVERSE, '0);
		repeat (6) send_request(blsr_pkg::MODE_POP, '0);
	endtask

	// Bursty random traffic: fill bursts drive the stack into overflow, drain
	// bursts run it dry, mixed bursts stir the middle.
	task automatic run_random_phase(int unsigned n_requests, int unsigned send_pct,
			int unsigned recv_pct);
		int unsigned             sent;
		int unsigned             burst_len;
		int unsigned             roll;
		burst_kind_t             kind;
		blsr_pkg::mode_t         op;
		logic signed [WIDTH-1:0] word;
		send_idle_pct = send_pct;
		recv_idle_pct = recv_pct;
		sent = 0;
		while (sent < n_requests) begin
			kind      = burst_kind_t'($urandom_range(2));
			burst_len = $urandom_range(1, 90);
			for (int i = 0; i < burst_len && sent < n_requests; i++) begin
				roll = $urandom_range(99);
				case (kind)
					BURST_FILL: begin
						if (roll < 86)      op = blsr_pkg::MODE_PUSH;
						else if (roll < 91) op = blsr_pkg::MODE_POP;
						else if (roll < 96) op = blsr_pkg::MODE_PEEK;
						else                op = blsr_pkg::MODE_REVERSE;
					end
					BURST_DRAIN: begin
						if (roll < 10)      op = blsr_pkg::MODE_PUSH;
						else if (roll < 82) op = blsr_pkg::MODE_POP;
						else if (roll < 94) op = blsr_pkg::MODE_PEEK;
						else                op = blsr_pkg::MODE_REVERSE;
					end
					default: begin
						if (roll < 35)      op = blsr_pkg::MODE_PUSH;
						else if (roll < 65) op = blsr_pkg::MODE_POP;
						else if (roll < 85) op = blsr_pkg::MODE_PEEK;
						else                op = blsr_pkg::MODE_REVERSE;
					end
				endcase
				// mostly full-range words, with the extremes mixed in
				case ($urandom_range(9))
					0:       word = 32'sh8000_0000;
					1:       word = 32'sh7FFF_FFFF;
					2:       word = -1;
					3:       word = '0;
					default: word = $urandom;
				endcase
				send_request(op, word);
				sent++;
			end
		end
	endtask

	task automatic test_random_traffic();
		run_random_phase(370, 32, 87);
		run_random_phase(370, 87, 32);
		run_random_phase(370, 0, 0);
	endtask

	initial begin
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_empty_reads();
		test_single_entry();
		test_reverse_orders();
		test_random_traffic();

		// release the request channel, let every expected result arrive
		@(negedge clk);
		req_valid <= 1'b0;
		while (expected_results.size() != 0)
			@(posedge clk);
		// hold a little longer so any stray extra result gets caught
		repeat (DRAIN_WAIT) @(posedge clk);

		if (mismatch_count == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

	// Watchdog: several times the slowest legal run.
	initial begin
		#10_000_000;
		$display("== FAIL ==");
		$finish;
	end

endmodule

[sim.f]
+incdir+hw/rtl
hw/rtl/blsr_pkg.sv
hw/rtl/blsr_ram.sv
hw/rtl/bounded_lifo_stack_with_reverse_top.sv
dv/tb_bounded_lifo_stack_with_reverse_top.sv
